@@ src/sclp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sclp_pkg
// Shared types, character codes and constants for the command line parser.
// ----------------------------------------------------------------------------
package sclp_pkg;

  localparam int WordMaxDefault   = 8;
  localparam int NumberMaxDefault = 5;

  localparam int WORD_DEPTH = 8;   // bytes in the word store
  localparam int POS_W      = 4;
  localparam int ZCNT_W     = 3;
  localparam int BYTE_W     = 8;
  localparam int TEXT_W     = WORD_DEPTH * BYTE_W;
  localparam int NUM_W      = 16;

  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'd13;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'd32;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'd0;

  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_LINE = 1'b1;

  typedef enum logic [1:0] {
    MODE_WORD   = 2'b01,
    MODE_NUMBER = 2'b10
  } mode_t;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] echo_byte;
    logic [TEXT_W-1:0] word_text;
    logic [NUM_W-1:0]  line_number;
  } result_t;

  // 10^(z+1) mod 2^16
  function automatic logic [NUM_W-1:0] scale_pow10(input logic [ZCNT_W-1:0] z);
    logic [NUM_W-1:0] p;
    case (z)
      3'd0:    p = 16'd10;
      3'd1:    p = 16'd100;
      3'd2:    p = 16'd1000;
      3'd3:    p = 16'd10000;
      3'd4:    p = 16'd34464;
      3'd5:    p = 16'd16960;
      3'd6:    p = 16'd38528;
      3'd7:    p = 16'd57600;
      default: p = 16'd10;
    endcase
    return p;
  endfunction

endpackage

@@ src/serial_command_line_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_line_parser
// Parses received bytes into "word number" lines; echoes each byte and
// reports the word and decimal value when a carriage return arrives.
// ----------------------------------------------------------------------------
// Channel   Ports                                            Direction
// input     in_valid, in_ready, in_rx_byte                   into block
// result    out_valid, out_ready, out_kind, out_echo_byte,   out of block
//           out_word_text, out_line_number
//
// One word in, one word out. A word is taken in the cycle it arrives and its
// result appears in the output register on the next cycle. Throughput is one
// word per cycle while in_ready is high; the parse state updates in one pass.
// in_ready is high when the output register is empty or being drained.
// Reset returns to word mode and clears the rest of the parse state and the word store to zero.
// ----------------------------------------------------------------------------
module serial_command_line_parser #(
  parameter int WORD_MAX   = sclp_pkg::WordMaxDefault,
  parameter int NUMBER_MAX = sclp_pkg::NumberMaxDefault
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sclp_pkg::BYTE_W-1:0]   in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_kind,
  output logic [sclp_pkg::BYTE_W-1:0]   out_echo_byte,
  output logic [sclp_pkg::TEXT_W-1:0]   out_word_text,
  output logic [sclp_pkg::NUM_W-1:0]    out_line_number
);
  import sclp_pkg::*;

  logic    take;
  result_t result;
  result_t res_r;
  logic    valid_r, valid_nxt;

  assign in_ready = !valid_r || out_ready;
  assign take     = in_valid && in_ready;

  sclp_core #(
    .WORD_MAX   (WORD_MAX),
    .NUMBER_MAX (NUMBER_MAX)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (in_rx_byte),
    .result  (result)
  );

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= result;
    end
  end

  assign out_valid       = valid_r;
  assign out_kind        = res_r.kind;
  assign out_echo_byte   = res_r.echo_byte;
  assign out_word_text   = res_r.word_text;
  assign out_line_number = res_r.line_number;

endmodule

@@ src/sclp_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sclp_core
// Parse state (mode, position, word store, decimal accumulator) and the
// result for the byte being taken this cycle.
// ----------------------------------------------------------------------------
module sclp_core #(
  parameter int WORD_MAX   = sclp_pkg::WordMaxDefault,
  parameter int NUMBER_MAX = sclp_pkg::NumberMaxDefault
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          take,
  input  logic [sclp_pkg::BYTE_W-1:0]   rx_byte,
  output sclp_pkg::result_t             result
);
  import sclp_pkg::*;

  localparam logic [POS_W-1:0] WordLimit   = POS_W'(WORD_MAX);
  localparam logic [POS_W-1:0] NumberLimit = POS_W'(NUMBER_MAX);
  localparam logic [POS_W-1:0] StoreLimit  = POS_W'(WORD_DEPTH);

  mode_t             mode_r, mode_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] store_r [WORD_DEPTH];
  logic [NUM_W-1:0]  acc_r, acc_nxt;
  logic [ZCNT_W-1:0] zcnt_r, zcnt_nxt;
  logic              seen_r, seen_nxt;

  logic              wr_en;
  logic [BYTE_W-1:0] wr_data;
  logic [TEXT_W-1:0] packed_text;
  logic [2*NUM_W-1:0] product;
  logic [NUM_W-1:0]  digit;

  always_comb begin
    for (int i = 0; i < WORD_DEPTH; i++) begin
      packed_text[i*BYTE_W +: BYTE_W] = store_r[i];
    end
  end

  assign product = acc_r * scale_pow10(zcnt_r);
  assign digit   = {{(NUM_W-BYTE_W){1'b0}}, rx_byte} - {{(NUM_W-BYTE_W){1'b0}}, CHAR_ZERO};

  always_comb begin
    mode_nxt = mode_r;
    pos_nxt  = pos_r;
    acc_nxt  = acc_r;
    zcnt_nxt = zcnt_r;
    seen_nxt = seen_r;
    wr_en    = 1'b0;
    wr_data  = rx_byte;

    result.kind        = KIND_ECHO;
    result.echo_byte   = rx_byte;
    result.word_text   = '0;
    result.line_number = '0;

    if (rx_byte == CHAR_CR) begin
      result.kind        = KIND_LINE;
      result.echo_byte   = CHAR_CR;
      result.word_text   = packed_text;
      result.line_number = acc_r;
      mode_nxt = MODE_WORD;
      pos_nxt  = '0;
      acc_nxt  = '0;
      zcnt_nxt = '0;
      seen_nxt = 1'b0;
    end else begin
      case (mode_r)
        MODE_WORD: begin
          if (pos_r >= WordLimit || rx_byte == CHAR_SPACE) begin
            // terminate the word when there is room for it
            wr_en    = (pos_r < StoreLimit);
            wr_data  = CHAR_NUL;
            mode_nxt = MODE_NUMBER;
            pos_nxt  = '0;
          end else begin
            wr_en   = (pos_r < StoreLimit);
            pos_nxt = pos_r + 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (pos_r < NumberLimit) begin
            if (rx_byte == CHAR_NUL) begin
              // zeros only count after an earlier digit and once a later digit follows
              if (seen_r) zcnt_nxt = zcnt_r + 1'b1;
            end else begin
              acc_nxt  = product[NUM_W-1:0] + digit;
              zcnt_nxt = '0;
              seen_nxt = 1'b1;
            end
            pos_nxt = pos_r + 1'b1;
          end
        end
        default: begin
          mode_nxt = MODE_WORD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_WORD;
      pos_r  <= '0;
      acc_r  <= '0;
      zcnt_r <= '0;
      seen_r <= 1'b0;
      for (int i = 0; i < WORD_DEPTH; i++) begin
        store_r[i] <= '0;
      end
    end else if (take) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      acc_r  <= acc_nxt;
      zcnt_r <= zcnt_nxt;
      seen_r <= seen_nxt;
      if (wr_en) begin
        store_r[pos_r[2:0]] <= wr_data;
      end
    end
  end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - serial_command_line_parser testbench
// Streams received bytes into the parser and checks every echo and every
// completed line against a cycle-free model of the word/number parse. Both
// channels stall at random; the receiver holds off for long stretches and
// the sender pauses now and then until all replies are back.
// ----------------------------------------------------------------------------
module tb;
  import sclp_pkg::*;

  localparam int WORD_LEN    = WordMaxDefault;
  localparam int DIGIT_LEN   = NumberMaxDefault;
  localparam int HOLD_CYCLES = 150;   // long receiver hold-off
  localparam int IDLE_LIMIT  = 2000;  // cycles with no word moving on either side
  localparam int TAIL_CYCLES = 4;

  typedef struct {
    logic [BYTE_W-1:0] b;
    bit                drain_first;  // wait until all replies are back
  } rx_item_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] in_rx_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_kind;
  logic [BYTE_W-1:0] out_echo_byte;
  logic [TEXT_W-1:0] out_word_text;
  logic [NUM_W-1:0]  out_line_number;

  rx_item_t rx_pending[$];
  result_t  expected_replies[$];
  int       results_got = 0;
  int       fail_count = 0;
  int       idle_cycles = 0;
  int       send_gap = 0;
  int       take_wait = 0;
  bit       send_steady = 1'b0;
  bit       take_steady = 1'b0;
  bit       mark_drain = 1'b0;

  // parser model state
  mode_t             mode = MODE_WORD;
  logic [POS_W-1:0]  pos = '0;
  logic [TEXT_W-1:0] word_mem = '0;
  logic [NUM_W-1:0]  value = '0;
  logic [ZCNT_W-1:0] zero_run = '0;
  bit                digit_seen = 1'b0;

  serial_command_line_parser #(
    .WORD_MAX  (WORD_LEN),
    .NUMBER_MAX(DIGIT_LEN)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_echo_byte  (out_echo_byte),
    .out_word_text  (out_word_text),
    .out_line_number(out_line_number)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advances the parse by one byte and returns the reply it produces.
  function automatic result_t parse_byte(input logic [BYTE_W-1:0] b);
    result_t          r;
    logic [NUM_W-1:0] acc;
    int               k;
    r = '0;
    r.echo_byte = b;
    if (b == CHAR_CR) begin
      r.kind        = KIND_LINE;
      r.word_text   = word_mem;
      r.line_number = value;
      mode       = MODE_WORD;
      pos        = '0;
      value      = '0;
      zero_run   = '0;
      digit_seen = 1'b0;
    end else begin
      r.kind = KIND_ECHO;
      if (mode == MODE_WORD) begin
        // word full: byte is dropped and the word ends; space: terminate the word
        if (pos >= WORD_LEN || b == CHAR_SPACE) begin
          if (pos < WORD_DEPTH) word_mem[pos*BYTE_W +: BYTE_W] = CHAR_NUL;
          mode = MODE_NUMBER;
          pos  = '0;
        end else begin
          word_mem[pos*BYTE_W +: BYTE_W] = b;
          pos = pos + 1'b1;
        end
      end else if (pos < DIGIT_LEN) begin
        if (b == CHAR_NUL) begin
          // NUL only counts as a digit after an earlier digit and once a later nonzero byte shows up
          if (digit_seen) zero_run = zero_run + 1'b1;
        end else begin
          acc = value;
          for (k = 0; k <= zero_run; k++) acc = acc * 16'd10;
          acc        = acc + {8'h00, b} - {8'h00, CHAR_ZERO};
          value      = acc;
          zero_run   = '0;
          digit_seen = 1'b1;
        end
        pos = pos + 1'b1;
      end
    end
    return r;
  endfunction

  task automatic push_byte(input logic [BYTE_W-1:0] b);
    rx_item_t item;
    item.b           = b;
    item.drain_first = mark_drain;
    mark_drain       = 1'b0;
    rx_pending.push_back(item);
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // driver
  always @(posedge clk) begin
    bit       next_valid;
    rx_item_t item;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      next_valid = in_valid;
      if (in_valid && in_ready) begin
        expected_replies.push_back(parse_byte(in_rx_byte));
        next_valid = 1'b0;
        if ($urandom_range(0, 31) == 0) send_steady = !send_steady;
        send_gap = send_steady ? 0 : $urandom_range(0, 8);
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (rx_pending.size() > 0 &&
                     !(rx_pending[0].drain_first && expected_replies.size() != 0)) begin
          item = rx_pending.pop_front();
          in_rx_byte <= item.b;
          next_valid = 1'b1;
        end
      end
      in_valid <= next_valid;
    end
  end

  // monitor / checker
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      take_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_got++;
        if (expected_replies.size() == 0) begin
          $error("unexpected reply word: kind %0d echo_byte %0h", out_kind, out_echo_byte);
          fail_count++;
        end else begin
          want = expected_replies.pop_front();
          if (out_kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_kind);
            fail_count++;
          end
          if (out_echo_byte !== want.echo_byte) begin
            $error("echo_byte: expected %0h, got %0h", want.echo_byte, out_echo_byte);
            fail_count++;
          end
          if (out_word_text !== want.word_text) begin
            $error("word_text: expected %016h, got %016h", want.word_text, out_word_text);
            fail_count++;
          end
          if (out_line_number !== want.line_number) begin
            $error("line_number: expected %0d, got %0d", want.line_number, out_line_number);
            fail_count++;
          end
        end
        if ($urandom_range(0, 31) == 0) take_steady = !take_steady;
        take_wait = take_steady ? 0 : $urandom_range(0, 8);
        // periodic long hold-off so the parser backs up into its input
        if (results_got % 500 == 250) take_wait = HOLD_CYCLES;
      end else if (take_wait > 0) begin
        take_wait--;
      end
      out_ready <= (take_wait == 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[serial_command_line_parser] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int total;
    int len;
    int i;
    bit noisy;

    // directed: full word with dropped byte, NUL handling, number overflow
    push_text("ab 12\r");
    push_text("abcdefgh");
    push_byte(8'hFF);               // word full, dropped
    push_byte(CHAR_NUL);            // leading NUL, ignored
    push_byte("7");
    push_byte(CHAR_NUL);            // inner NUL, counts as 0
    push_byte("9");
    push_byte(CHAR_NUL);            // trailing NUL, ignored
    push_byte(CHAR_SPACE);          // number full, ignored
    push_byte(CHAR_CR);
    push_text("q\r");               // old word bytes show through
    push_byte(CHAR_SPACE);          // empty word
    push_byte(8'hFF);               // non-digit bytes still enter the value
    push_byte(8'h01);
    push_byte(CHAR_CR);
    push_byte(CHAR_CR);             // empty line

    // random lines; mostly well formed, some raw noise
    mark_drain = 1'b1;
    while (rx_pending.size() < 2020) begin
      if ($urandom_range(0, 39) == 0) mark_drain = 1'b1;
      noisy = ($urandom_range(0, 6) == 0);
      if (noisy) begin
        len = $urandom_range(1, 12);
        for (i = 0; i < len; i++) push_byte(BYTE_W'($urandom_range(0, 255)));
      end else begin
        len = $urandom_range(0, 10);
        for (i = 0; i < len; i++)
          push_byte(($urandom_range(0, 3) == 0) ? BYTE_W'($urandom_range(0, 255))
                                                : BYTE_W'($urandom_range(97, 122)));
        if (len < WORD_LEN || $urandom_range(0, 1)) push_byte(CHAR_SPACE);
        len = $urandom_range(0, 7);
        for (i = 0; i < len; i++)
          push_byte(($urandom_range(0, 7) == 0) ? CHAR_NUL
                                                : BYTE_W'($urandom_range(48, 57)));
        push_byte(CHAR_CR);
      end
    end
    total = rx_pending.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (results_got < total) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (expected_replies.size() != 0) begin
      $error("%0d replies never arrived", expected_replies.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("[serial_command_line_parser] OK");
    else
      $display("[serial_command_line_parser] ERROR");
    $finish;
  end

endmodule
